// ===== rtl/wgsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgsp_pkg
// Shared types and constants for the weighted graph shortest path block.
// ----------------------------------------------------------------------------
package wgsp_pkg;

   // Fixed widths of the channel fields.
   localparam int OPCODE_W = 3;
   localparam int VERTEX_W = 4;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 19;
   localparam int DIST_MAX = 524287;

   // Item opcodes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD_VERTEX = 3'd0,
      OP_REM_VERTEX = 3'd1,
      OP_ADD_EDGE   = 3'd2,
      OP_REM_EDGE   = 3'd3,
      OP_UPD_EDGE   = 3'd4,
      OP_PATH       = 3'd5
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_EXEC,
      CMD_WR2,
      CMD_QINIT,
      CMD_SCAN,
      CMD_SDRAIN,
      CMD_SETTLE,
      CMD_RELAX,
      CMD_RDRAIN,
      CMD_WALK_WR,
      CMD_WALK_RD,
      CMD_EMIT_RD,
      CMD_EMIT_OUT,
      CMD_RESP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last;
   } ctl_cmd_type;

   typedef struct packed {
      logic exec_ok;
      logic edge_wr2;
      logic query;
      logic found;
      logic at_goal;
      logic at_start;
      logic rsp_busy;
   } dp_status_type;

endpackage

// ===== rtl/wgsp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgsp_req_if
// Request channel: one graph operation per beat.
// ----------------------------------------------------------------------------
interface wgsp_req_if;
   logic                              valid;
   logic                              ready;
   logic [wgsp_pkg::OPCODE_W-1:0]     opcode;
   logic [wgsp_pkg::VERTEX_W-1:0]     vertex_a;
   logic [wgsp_pkg::VERTEX_W-1:0]     vertex_b;
   logic signed [wgsp_pkg::WEIGHT_W-1:0] weight;

   modport source (output valid, output opcode, output vertex_a, output vertex_b,
                   output weight, input ready);
   modport sink   (input valid, input opcode, input vertex_a, input vertex_b,
                   input weight, output ready);
endinterface

// ===== rtl/wgsp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgsp_rsp_if
// Response channel: one status or path vertex per beat.
// ----------------------------------------------------------------------------
interface wgsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [wgsp_pkg::VERTEX_W-1:0] path_vertex;
   logic [wgsp_pkg::DIST_W-1:0]   distance;
   logic                          last;

   modport source (output valid, output ok, output path_vertex, output distance,
                   output last, input ready);
   modport sink   (input valid, input ok, input path_vertex, input distance,
                   input last, output ready);
endinterface

// ===== rtl/wgsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgsp_dp
// Graph storage, Dijkstra scan and relax pipeline, path walk and response
// register.
// ----------------------------------------------------------------------------
module wgsp_dp #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 15,
   localparam int VW = $clog2(MAX_VERTICES)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wgsp_pkg::ctl_cmd_type            cmd,
   input  logic [VW-1:0]                    idx,
   input  logic                             load,
   input  logic [wgsp_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [wgsp_pkg::VERTEX_W-1:0]    req_vertex_a,
   input  logic [wgsp_pkg::VERTEX_W-1:0]    req_vertex_b,
   input  logic [wgsp_pkg::WEIGHT_W-1:0]    req_weight,
   output wgsp_pkg::dp_status_type          status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic [wgsp_pkg::VERTEX_W-1:0]    rsp_path_vertex,
   output logic [wgsp_pkg::DIST_W-1:0]      rsp_distance,
   output logic                             rsp_last
);

   localparam int NV = MAX_VERTICES;
   localparam int DW = WEIGHT_BITS + VW;
   localparam int NE = NV * NV;
   localparam int AW = $clog2(NE);
   localparam int OW = (DW > wgsp_pkg::DIST_W) ? DW : wgsp_pkg::DIST_W;
   localparam logic [31:0] WMAX = (32'd1 << WEIGHT_BITS) - 32'd1;

   // Item registers.
   logic [wgsp_pkg::OPCODE_W-1:0] op_ff;
   logic [wgsp_pkg::VERTEX_W-1:0] a_ff, b_ff;
   logic [wgsp_pkg::WEIGHT_W-1:0] w_ff;

   // Graph and search state.
   logic [NV-1:0]          vp_ff, reach_ff, visit_ff;
   logic [NV-1:0]          ep_ff [NV];
   logic [WEIGHT_BITS-1:0] wmem [NE];
   logic [WEIGHT_BITS-1:0] w_rd_ff;
   logic [DW-1:0]          dmem [NV];
   logic [DW-1:0]          dist_rd_ff;
   logic [VW-1:0]          pmem [NV];
   logic [VW-1:0]          p_rd_ff;
   logic [VW-1:0]          pbmem [NV];
   logic [VW-1:0]          pb_rd_ff;

   // Pipeline stage and search registers.
   logic          sc_vld_ff, rx_vld_ff;
   logic [VW-1:0] stg_ff;
   logic          found_ff;
   logic [DW-1:0] best_ff;
   logic [VW-1:0] u_ff, cur_ff;
   logic          ok_ff;

   // Response register.
   logic                          rsp_vld_ff, rsp_ok_ff, rsp_last_ff;
   logic [wgsp_pkg::VERTEX_W-1:0] rsp_pv_ff;
   logic [wgsp_pkg::DIST_W-1:0]   rsp_dist_ff;

   logic          a_rng, b_rng, a_pres, b_pres, w_ok, ab_edge, exec_ok, is_edge_wr;
   logic [VW-1:0] a_idx, b_idx;
   logic          sc_take, rx_upd;
   logic [DW-1:0] nd;
   logic          wme;
   logic [AW-1:0] wwaddr, wraddr;
   logic [OW-1:0] dext;
   logic [wgsp_pkg::DIST_W-1:0] dist_sat;

   // Operand checks on the held item.
   assign a_rng   = int'(a_ff) < NV;
   assign b_rng   = int'(b_ff) < NV;
   assign a_idx   = VW'(a_ff);
   assign b_idx   = VW'(b_ff);
   assign a_pres  = a_rng && vp_ff[a_idx];
   assign b_pres  = b_rng && vp_ff[b_idx];
   assign w_ok    = !w_ff[wgsp_pkg::WEIGHT_W-1] && (32'(w_ff) <= WMAX);
   assign ab_edge = ep_ff[a_idx][b_idx];

   always_comb begin
      case (op_ff)
         wgsp_pkg::OP_ADD_VERTEX: exec_ok = a_rng && !vp_ff[a_idx];
         wgsp_pkg::OP_REM_VERTEX: exec_ok = a_pres;
         wgsp_pkg::OP_ADD_EDGE:   exec_ok = w_ok && a_pres && b_pres;
         wgsp_pkg::OP_UPD_EDGE:   exec_ok = w_ok && a_pres && b_pres && ab_edge;
         wgsp_pkg::OP_REM_EDGE:   exec_ok = a_pres && b_pres && ab_edge;
         wgsp_pkg::OP_PATH:       exec_ok = a_pres && b_pres;
         default:                 exec_ok = 1'b0;
      endcase
   end

   assign is_edge_wr = (op_ff == wgsp_pkg::OP_ADD_EDGE) || (op_ff == wgsp_pkg::OP_UPD_EDGE);

   assign status.exec_ok  = exec_ok;
   assign status.edge_wr2 = exec_ok && is_edge_wr;
   assign status.query    = exec_ok && (op_ff == wgsp_pkg::OP_PATH);
   assign status.found    = found_ff;
   assign status.at_goal  = (u_ff == b_idx);
   assign status.at_start = (cur_ff == a_idx);
   assign status.rsp_busy = rsp_vld_ff;

   // Scan stage: keep the lowest-distance unsettled reached vertex, lowest index on ties.
   assign sc_take = sc_vld_ff && vp_ff[stg_ff] && reach_ff[stg_ff] && !visit_ff[stg_ff] &&
                    (!found_ff || (dist_rd_ff < best_ff));

   // Relax stage: a strictly shorter distance through the settled vertex wins.
   assign nd     = best_ff + DW'(w_rd_ff);
   assign rx_upd = rx_vld_ff && vp_ff[stg_ff] && !visit_ff[stg_ff] && ep_ff[u_ff][stg_ff] &&
                   (!reach_ff[stg_ff] || (nd < dist_rd_ff));

   // Weight memory addressing: forward direction first, then the mirror entry.
   assign wme    = ((cmd.kind == wgsp_pkg::CMD_EXEC) && exec_ok && is_edge_wr) ||
                   (cmd.kind == wgsp_pkg::CMD_WR2);
   assign wwaddr = (cmd.kind == wgsp_pkg::CMD_WR2) ?
                   AW'(b_idx) * AW'(NV) + AW'(a_idx) :
                   AW'(a_idx) * AW'(NV) + AW'(b_idx);
   assign wraddr = AW'(u_ff) * AW'(NV) + AW'(idx);

   // Reported distance saturates at the field maximum.
   assign dext     = OW'(best_ff);
   assign dist_sat = (dext > OW'(wgsp_pkg::DIST_MAX)) ?
                     wgsp_pkg::DIST_W'(wgsp_pkg::DIST_MAX) : dext[wgsp_pkg::DIST_W-1:0];

   // Item capture.
   always_ff @(posedge clock) begin
      if (load) begin
         op_ff <= req_opcode;
         a_ff  <= req_vertex_a;
         b_ff  <= req_vertex_b;
         w_ff  <= req_weight;
      end
   end

   // Memories: weights, distances, predecessors and the path buffer.
   always_ff @(posedge clock) begin
      if (wme) begin
         wmem[wwaddr] <= WEIGHT_BITS'(w_ff);
      end
      w_rd_ff <= wmem[wraddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.kind == wgsp_pkg::CMD_QINIT) begin
         dmem[a_idx] <= '0;
         pmem[a_idx] <= a_idx;
      end else if (rx_upd) begin
         dmem[stg_ff] <= nd;
         pmem[stg_ff] <= u_ff;
      end
      dist_rd_ff <= dmem[idx];
      p_rd_ff    <= pmem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.kind == wgsp_pkg::CMD_WALK_WR) begin
         pbmem[idx] <= cur_ff;
      end
      pb_rd_ff <= pbmem[idx];
   end

   // Search payload registers.
   always_ff @(posedge clock) begin
      stg_ff <= idx;
      if (sc_take) begin
         best_ff <= dist_rd_ff;
         u_ff    <= stg_ff;
      end
      if (cmd.kind == wgsp_pkg::CMD_QINIT) begin
         cur_ff <= b_idx;
      end else if (cmd.kind == wgsp_pkg::CMD_WALK_RD) begin
         cur_ff <= p_rd_ff;
      end
      if (cmd.kind == wgsp_pkg::CMD_EXEC) begin
         ok_ff <= exec_ok;
      end else if (cmd.kind == wgsp_pkg::CMD_SETTLE) begin
         ok_ff <= found_ff;
      end
   end

   // Control state: presence bits, edge bits, search marks, stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff     <= '0;
         reach_ff  <= '0;
         visit_ff  <= '0;
         found_ff  <= 1'b0;
         sc_vld_ff <= 1'b0;
         rx_vld_ff <= 1'b0;
         for (int i = 0; i < NV; i++) begin
            ep_ff[i] <= '0;
         end
      end else begin
         sc_vld_ff <= (cmd.kind == wgsp_pkg::CMD_SCAN);
         rx_vld_ff <= (cmd.kind == wgsp_pkg::CMD_RELAX);
         if (sc_take) begin
            found_ff <= 1'b1;
         end
         if (rx_upd) begin
            reach_ff[stg_ff] <= 1'b1;
         end
         case (cmd.kind)
            wgsp_pkg::CMD_EXEC: begin
               if (exec_ok) begin
                  case (op_ff)
                     wgsp_pkg::OP_ADD_VERTEX: vp_ff[a_idx] <= 1'b1;
                     wgsp_pkg::OP_REM_VERTEX: begin
                        vp_ff[a_idx] <= 1'b0;
                        // Clear the vertex row and its column in every other row.
                        for (int i = 0; i < NV; i++) begin
                           if (VW'(i) == a_idx) begin
                              ep_ff[i] <= '0;
                           end else begin
                              ep_ff[i] <= ep_ff[i] & ~(NV'(1) << a_idx);
                           end
                        end
                     end
                     wgsp_pkg::OP_ADD_EDGE, wgsp_pkg::OP_UPD_EDGE: begin
                        ep_ff[a_idx][b_idx] <= 1'b1;
                        ep_ff[b_idx][a_idx] <= 1'b1;
                     end
                     wgsp_pkg::OP_REM_EDGE: begin
                        ep_ff[a_idx][b_idx] <= 1'b0;
                        ep_ff[b_idx][a_idx] <= 1'b0;
                     end
                     default: ;
                  endcase
               end
            end
            wgsp_pkg::CMD_QINIT: begin
               visit_ff <= '0;
               reach_ff <= NV'(1) << a_idx;
               found_ff <= 1'b0;
            end
            wgsp_pkg::CMD_SETTLE: begin
               if (found_ff) begin
                  visit_ff[u_ff] <= 1'b1;
               end
            end
            wgsp_pkg::CMD_RDRAIN: found_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   // Response register: loaded only when empty, cleared when the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_vld_ff) begin
         if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end else if ((cmd.kind == wgsp_pkg::CMD_EMIT_OUT) || (cmd.kind == wgsp_pkg::CMD_RESP)) begin
         rsp_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_vld_ff) begin
         if (cmd.kind == wgsp_pkg::CMD_EMIT_OUT) begin
            rsp_ok_ff   <= 1'b1;
            rsp_pv_ff   <= wgsp_pkg::VERTEX_W'(pb_rd_ff);
            rsp_dist_ff <= dist_sat;
            rsp_last_ff <= cmd.last;
         end else if (cmd.kind == wgsp_pkg::CMD_RESP) begin
            rsp_ok_ff   <= ok_ff;
            rsp_pv_ff   <= '0;
            rsp_dist_ff <= '0;
            rsp_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_path_vertex = rsp_pv_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/wgsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgsp_ctrl
// Sequencer for graph edits, the Dijkstra scan/relax loop and path output.
// ----------------------------------------------------------------------------
module wgsp_ctrl #(
   parameter int MAX_VERTICES = 16,
   localparam int VW = $clog2(MAX_VERTICES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   output logic                    req_ready,
   input  wgsp_pkg::dp_status_type status,
   output wgsp_pkg::ctl_cmd_type   cmd,
   output logic [VW-1:0]           idx
);

   localparam int CW = VW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_WR2, ST_QINIT, ST_SCAN, ST_SDRAIN, ST_SETTLE,
      ST_RELAX, ST_RDRAIN, ST_WALK_WR, ST_WALK_RD, ST_EMIT_RD, ST_EMIT_OUT, ST_RESP
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_m1;
   logic          cnt_end;

   assign cnt_m1  = cnt_ff - CW'(1);
   assign cnt_end = (cnt_ff == CW'(MAX_VERTICES - 1));

   // Next state and counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: if (load) state_in = ST_EXEC;
         ST_EXEC: begin
            if (status.edge_wr2) state_in = ST_WR2;
            else if (status.query) state_in = ST_QINIT;
            else state_in = ST_RESP;
         end
         ST_WR2:   state_in = ST_RESP;
         ST_QINIT: begin
            state_in = ST_SCAN;
            cnt_in   = '0;
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_end) state_in = ST_SDRAIN;
         end
         ST_SDRAIN: state_in = ST_SETTLE;
         ST_SETTLE: begin
            cnt_in = '0;
            if (!status.found) state_in = ST_RESP;
            else if (status.at_goal) state_in = ST_WALK_WR;
            else state_in = ST_RELAX;
         end
         ST_RELAX: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_end) state_in = ST_RDRAIN;
         end
         ST_RDRAIN: begin
            state_in = ST_SCAN;
            cnt_in   = '0;
         end
         ST_WALK_WR: begin
            cnt_in = cnt_ff + CW'(1);
            if (status.at_start || cnt_end) state_in = ST_EMIT_RD;
            else state_in = ST_WALK_RD;
         end
         ST_WALK_RD: state_in = ST_WALK_WR;
         ST_EMIT_RD: begin
            cnt_in   = cnt_m1;
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!status.rsp_busy) state_in = (cnt_ff == '0) ? ST_IDLE : ST_EMIT_RD;
         end
         ST_RESP: if (!status.rsp_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Command decode.
   always_comb begin
      cmd.last = (cnt_ff == '0);
      idx      = cnt_ff[VW-1:0];
      case (state_ff)
         ST_IDLE:     cmd.kind = wgsp_pkg::CMD_IDLE;
         ST_EXEC:     cmd.kind = wgsp_pkg::CMD_EXEC;
         ST_WR2:      cmd.kind = wgsp_pkg::CMD_WR2;
         ST_QINIT:    cmd.kind = wgsp_pkg::CMD_QINIT;
         ST_SCAN:     cmd.kind = wgsp_pkg::CMD_SCAN;
         ST_SDRAIN:   cmd.kind = wgsp_pkg::CMD_SDRAIN;
         ST_SETTLE:   cmd.kind = wgsp_pkg::CMD_SETTLE;
         ST_RELAX:    cmd.kind = wgsp_pkg::CMD_RELAX;
         ST_RDRAIN:   cmd.kind = wgsp_pkg::CMD_RDRAIN;
         ST_WALK_WR:  cmd.kind = wgsp_pkg::CMD_WALK_WR;
         ST_WALK_RD:  cmd.kind = wgsp_pkg::CMD_WALK_RD;
         ST_EMIT_RD: begin
            cmd.kind = wgsp_pkg::CMD_EMIT_RD;
            idx      = cnt_m1[VW-1:0];
         end
         ST_EMIT_OUT: cmd.kind = wgsp_pkg::CMD_EMIT_OUT;
         ST_RESP:     cmd.kind = wgsp_pkg::CMD_RESP;
         default:     cmd.kind = wgsp_pkg::CMD_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== rtl/weighted_graph_shortest_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_graph_shortest_path
// Undirected weighted graph with vertex/edge edits and Dijkstra path queries.
// ----------------------------------------------------------------------------
//  Channel    Direction  Beat carries
//  req_chan   in         opcode, vertex_a, vertex_b, weight
//  rsp_chan   out        ok, path_vertex, distance, last
//
// Vertex and edge edits go through the execute state, an edge write also
// through a mirror write state, before the response beat is loaded.
// A path query runs a scan pass and a relax pass over the distance memory
// for each settled vertex, at one vertex per cycle, then a predecessor walk
// and output for each path vertex.
// Synchronous reset clears all presence and edge bits; no clearing pass.
// A stalled response holds the sequencer but a new item is taken once idle.
// ----------------------------------------------------------------------------
module weighted_graph_shortest_path #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 15
) (
   input  logic        clock,
   input  logic        reset,
   wgsp_req_if.sink    req_chan,
   wgsp_rsp_if.source  rsp_chan
);

   localparam int VW = $clog2(MAX_VERTICES);

   wgsp_pkg::ctl_cmd_type   cmd;
   wgsp_pkg::dp_status_type status;
   logic [VW-1:0]           idx;
   logic                    load;

   assign load = req_chan.valid && req_chan.ready;

   wgsp_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd),
      .idx       (idx)
   );

   wgsp_dp #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .idx             (idx),
      .load            (load),
      .req_opcode      (req_chan.opcode),
      .req_vertex_a    (req_chan.vertex_a),
      .req_vertex_b    (req_chan.vertex_b),
      .req_weight      (req_chan.weight),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_ok          (rsp_chan.ok),
      .rsp_path_vertex (rsp_chan.path_vertex),
      .rsp_distance    (rsp_chan.distance),
      .rsp_last        (rsp_chan.last)
   );

`ifndef SYNTHESIS
   // Once an item is taken, the block is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while previous item still in progress");

   // A failure is always a single, final beat with empty path fields.
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ok) |->
         (rsp_chan.last && (rsp_chan.distance == '0) && (rsp_chan.path_vertex == '0)))
      else $error("failure response with path content or without last");
`endif

endmodule
